// File: sv/afi_pkg.sv
// ----------------------------------------------------------------------------
// afi_pkg
// Shared types and constants for the alpha fade interpolator: controller
// states, the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package afi_pkg;

   // Fixed field widths of the request and response beats.
   localparam int ALPHA_WIDTH  = 8;
   localparam int LAYER_WIDTH  = 8;
   localparam int SERIAL_WIDTH = 32;
   localparam int TICK_WIDTH   = 16;

   // The quotient of the interpolation is always below 2**ALPHA_WIDTH, so the
   // divider resolves one quotient bit per step over this many steps.
   localparam int DIV_STEPS    = ALPHA_WIDTH;
   localparam int STEP_BITS    = $clog2(DIV_STEPS);

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_FIN,
      ST_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_item;    // Apply a request beat to the fade state.
      logic mul_load;     // Form the scaled delta and seed the divider.
      logic div_step;     // Resolve one quotient bit.
      logic write_alpha;  // Commit the interpolated alpha.
      logic load_rsp;     // Move the result into the output register.
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_interp;  // The beat being accepted needs an interpolation.
      logic rsp_free;     // The output register can take a result.
   } status_type;

endpackage

// File: sv/afi_controller.sv
// ----------------------------------------------------------------------------
// afi_controller
// Sequencer for one tick: accept, optional multiply and eight divide steps,
// alpha commit, then hand-off to the output register.
// ----------------------------------------------------------------------------
module afi_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  afi_pkg::status_type status,
   output afi_pkg::cmd_type    cmd
);
   import afi_pkg::*;

   state_type             state_ff, state_in;
   logic [STEP_BITS-1:0]  step_ff,  step_in;
   logic                  accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Next state and divide step count.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = status.need_interp ? ST_MUL : ST_OUT;
            end
         end
         ST_MUL: begin
            state_in = ST_DIV;
            step_in  = '0;
         end
         ST_DIV: begin
            if (step_ff == STEP_BITS'(DIV_STEPS - 1)) begin
               state_in = ST_FIN;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_FIN: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: cmd.load_item   = accept;
         ST_MUL:  cmd.mul_load    = 1'b1;
         ST_DIV:  cmd.div_step    = 1'b1;
         ST_FIN:  cmd.write_alpha = 1'b1;
         ST_OUT:  cmd.load_rsp    = status.rsp_free;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// File: sv/afi_datapath.sv
// ----------------------------------------------------------------------------
// afi_datapath
// Fade state, elapsed-time update, delta multiplier, bit-serial divider and
// the output register of the response channel.
// ----------------------------------------------------------------------------
module afi_datapath #(
   parameter int TIME_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  afi_pkg::cmd_type                     cmd,
   output afi_pkg::status_type                  status,
   input  logic [afi_pkg::TICK_WIDTH-1:0]       req_tick_ms,
   input  logic [afi_pkg::SERIAL_WIDTH-1:0]     req_request_serial,
   input  logic [afi_pkg::LAYER_WIDTH-1:0]      req_request_layers,
   input  logic [afi_pkg::ALPHA_WIDTH-1:0]      req_request_alpha,
   input  logic [afi_pkg::TICK_WIDTH-1:0]       req_request_length_ms,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [afi_pkg::ALPHA_WIDTH-1:0]      rsp_alpha_now,
   output logic                                 rsp_fading,
   output logic [afi_pkg::LAYER_WIDTH-1:0]      rsp_layers_now
);
   import afi_pkg::*;

   localparam int PROD_WIDTH = TIME_WIDTH + ALPHA_WIDTH;

   // Fade state.
   logic [SERIAL_WIDTH-1:0] serial_ff,   serial_in;
   logic                    prog_ff,     prog_in;
   logic [LAYER_WIDTH-1:0]  layers_ff,   layers_in;
   logic [ALPHA_WIDTH-1:0]  cur_ff,      cur_in;
   logic [ALPHA_WIDTH-1:0]  origin_ff,   origin_in;
   logic [ALPHA_WIDTH-1:0]  goal_ff,     goal_in;
   logic [TIME_WIDTH-1:0]   len_ff,      len_in;
   logic [TIME_WIDTH-1:0]   spent_ff,    spent_in;

   // Divider.
   logic [TIME_WIDTH-1:0]   rem_ff;
   logic [ALPHA_WIDTH-1:0]  low_ff;
   logic [ALPHA_WIDTH-1:0]  quot_ff;
   logic                    neg_ff;

   // Output register.
   logic                    rsp_valid_ff;
   logic [ALPHA_WIDTH-1:0]  rsp_alpha_ff;
   logic                    rsp_fading_ff;
   logic [LAYER_WIDTH-1:0]  rsp_layers_ff;

   logic [31:0]             tick_ext, length_ext;
   logic [TIME_WIDTH-1:0]   tick_t, length_t, remaining;
   logic                    new_fade, need_interp;
   logic [ALPHA_WIDTH-1:0]  mag;
   logic [PROD_WIDTH-1:0]   product;
   logic [TIME_WIDTH:0]     trial;
   logic [TIME_WIDTH:0]     trial_diff;

   // Time fields are taken at TIME_WIDTH bits.
   assign tick_ext   = 32'(req_tick_ms);
   assign length_ext = 32'(req_request_length_ms);
   assign tick_t     = tick_ext[TIME_WIDTH-1:0];
   assign length_t   = length_ext[TIME_WIDTH-1:0];

   // Request beat: start a new fade on a serial change, then advance time.
   always_comb begin
      serial_in   = serial_ff;
      prog_in     = prog_ff;
      layers_in   = layers_ff;
      cur_in      = cur_ff;
      origin_in   = origin_ff;
      goal_in     = goal_ff;
      len_in      = len_ff;
      spent_in    = spent_ff;
      need_interp = 1'b0;
      remaining   = '0;
      new_fade    = (req_request_serial != serial_ff);
      if (new_fade) begin
         serial_in = req_request_serial;
         layers_in = req_request_layers;
         origin_in = cur_ff;
         goal_in   = req_request_alpha;
         len_in    = length_t;
         spent_in  = '0;
         prog_in   = (length_t != '0);
         if (length_t == '0) begin
            cur_in = req_request_alpha;
         end
      end
      if (prog_in) begin
         remaining = (spent_in < len_in) ? (len_in - spent_in) : '0;
         if (tick_t >= remaining) begin
            spent_in = len_in;
            cur_in   = goal_in;
            prog_in  = 1'b0;
         end else begin
            // The sum stays below the length, so it cannot wrap.
            spent_in    = spent_in + tick_t;
            need_interp = 1'b1;
         end
      end
   end

   // Magnitude of the alpha delta and its product with the elapsed time.
   assign mag     = (goal_ff >= origin_ff) ? (goal_ff - origin_ff) : (origin_ff - goal_ff);
   assign product = PROD_WIDTH'(mag) * PROD_WIDTH'(spent_ff);

   // One restoring divide step; the partial remainder stays below the length.
   assign trial      = {rem_ff, low_ff[ALPHA_WIDTH-1]};
   assign trial_diff = trial - {1'b0, len_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         serial_ff <= '0;
         prog_ff   <= 1'b0;
         layers_ff <= '0;
         cur_ff    <= '0;
         origin_ff <= '0;
         goal_ff   <= '0;
         len_ff    <= '0;
         spent_ff  <= '0;
      end else if (cmd.load_item) begin
         serial_ff <= serial_in;
         prog_ff   <= prog_in;
         layers_ff <= layers_in;
         cur_ff    <= cur_in;
         origin_ff <= origin_in;
         goal_ff   <= goal_in;
         len_ff    <= len_in;
         spent_ff  <= spent_in;
      end else if (cmd.write_alpha) begin
         // The quotient never exceeds the delta, so the result stays in range.
         cur_ff <= neg_ff ? (origin_ff - quot_ff) : (origin_ff + quot_ff);
      end
   end

   // Divider seeding and stepping.
   always_ff @(posedge clock) begin
      if (cmd.mul_load) begin
         rem_ff  <= product[PROD_WIDTH-1:ALPHA_WIDTH];
         low_ff  <= product[ALPHA_WIDTH-1:0];
         quot_ff <= '0;
         neg_ff  <= (goal_ff < origin_ff);
      end else if (cmd.div_step) begin
         low_ff <= {low_ff[ALPHA_WIDTH-2:0], 1'b0};
         if (!trial_diff[TIME_WIDTH] && (trial >= {1'b0, len_ff})) begin
            rem_ff  <= trial_diff[TIME_WIDTH-1:0];
            quot_ff <= {quot_ff[ALPHA_WIDTH-2:0], 1'b1};
         end else begin
            rem_ff  <= trial[TIME_WIDTH-1:0];
            quot_ff <= {quot_ff[ALPHA_WIDTH-2:0], 1'b0};
         end
      end
   end

   // Output register of the response channel.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_alpha_ff  <= cur_ff;
         rsp_fading_ff <= prog_ff;
         rsp_layers_ff <= layers_ff;
      end
   end

   assign status.need_interp = need_interp;
   assign status.rsp_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_alpha_now  = rsp_alpha_ff;
   assign rsp_fading     = rsp_fading_ff;
   assign rsp_layers_now = rsp_layers_ff;

   // An active fade has not yet used up its length.
   a_prog_bounded: assert property (@(posedge clock) disable iff (reset)
      prog_ff |-> (spent_ff < len_ff))
      else $error("active fade with elapsed time at or past its length");

   // The partial remainder stays below the divisor on every step.
   a_rem_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (rem_ff < len_ff))
      else $error("divider remainder not below the fade length");

   // A loaded result is presented on the next cycle.
   a_rsp_loaded: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid_ff)
      else $error("result loaded but response not valid");

   // A result is only loaded when the output register can take it.
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a pending response");

endmodule

// File: sv/alpha_fade_interpolator_core.sv
// ----------------------------------------------------------------------------
// alpha_fade_interpolator_core
// Linear alpha fade interpolator: one response beat per tick beat.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one tick beat: elapsed milliseconds and the
//   latest fade request (serial, layer mask, target alpha, length). A serial
//   that differs from the stored one starts a new fade from the current alpha.
//   The rsp_ channel returns exactly one beat per tick beat with the alpha
//   after the tick, the fading flag and the active layer mask.
//   A tick that needs no interpolation goes from accept straight to the output
//   load; a tick inside a fade first passes a multiply step, eight restoring
//   divide steps of the bit-serial divider and an alpha commit step, then the
//   output load. The next tick beat is accepted in the cycle after the response
//   is loaded, so no new tick is taken before the last result is loaded.
//   A finished response waits in the output register while the next tick is
//   accepted and processed; if the receiver still stalls, the controller holds
//   the new result until the output register frees up.
//   Reset (synchronous, active high) clears all fade state to zero and drops
//   rsp_valid; the block is ready for a tick as soon as reset is released.
// ----------------------------------------------------------------------------
module alpha_fade_interpolator_core #(
   parameter int TIME_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [afi_pkg::TICK_WIDTH-1:0]       req_tick_ms,
   input  logic [afi_pkg::SERIAL_WIDTH-1:0]     req_request_serial,
   input  logic [afi_pkg::LAYER_WIDTH-1:0]      req_request_layers,
   input  logic [afi_pkg::ALPHA_WIDTH-1:0]      req_request_alpha,
   input  logic [afi_pkg::TICK_WIDTH-1:0]       req_request_length_ms,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [afi_pkg::ALPHA_WIDTH-1:0]      rsp_alpha_now,
   output logic                                 rsp_fading,
   output logic [afi_pkg::LAYER_WIDTH-1:0]      rsp_layers_now
);
   import afi_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   afi_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Fade state, arithmetic and output register.
   afi_datapath #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_tick_ms           (req_tick_ms),
      .req_request_serial    (req_request_serial),
      .req_request_layers    (req_request_layers),
      .req_request_alpha     (req_request_alpha),
      .req_request_length_ms (req_request_length_ms),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_alpha_now         (rsp_alpha_now),
      .rsp_fading            (rsp_fading),
      .rsp_layers_now        (rsp_layers_now)
   );

endmodule
